// ===== rtl/core/wam_pkg.sv =====
// Shared widths and codes for the windowed average alarm monitor.
`timescale 1ns / 1ps
`default_nettype none
package wam_pkg;

  localparam int TEMP_W  = 20;
  localparam int PRES_W  = 24;
  localparam int RLIM_W  = 19;
  localparam int STAT_W  = 2;
  localparam int AVG_W   = 20;
  localparam int RISE_W  = 21;
  localparam int CFG_DW  = 32;
  localparam int CFG_AW  = 4;
  localparam int REG_IW  = 2;

  typedef logic [STAT_W-1:0] status_t;
  typedef logic [REG_IW-1:0] reg_idx_t;

  localparam status_t STATUS_NORMAL   = 2'd0;
  localparam status_t STATUS_MELTDOWN = 2'd1;
  localparam status_t STATUS_RISE     = 2'd2;

  localparam reg_idx_t REG_PRES_LIMIT = 2'd0;
  localparam reg_idx_t REG_TEMP_LIMIT = 2'd1;
  localparam reg_idx_t REG_RISE_LIMIT = 2'd2;

  localparam logic [PRES_W-1:0] PRES_LIMIT_RST = 24'd24000;
  localparam logic [TEMP_W-1:0] TEMP_LIMIT_RST = 20'd32000;
  localparam logic [RLIM_W-1:0] RISE_LIMIT_RST = 19'd80;

endpackage
`default_nettype wire

// ===== rtl/core/wam_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module wam_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 10
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wam_div.sv =====
// Iterative restoring divider: signed dividend by unsigned divisor, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module wam_div
  import wam_pkg::*;
#(
  parameter int DVD_W = 24,
  parameter int DVS_W = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [DVD_W-1:0] dividend,
  input  wire logic        [DVS_W-1:0] divisor,
  output logic                         done,
  output logic signed [AVG_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   rem_sh;
  logic             fits;
  logic [DVS_W:0]   rem_sub;
  logic [DVD_W-1:0] quo_nxt;
  logic [DVS_W-1:0] rem_nxt;
  logic [DVD_W-1:0] qsigned;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    fits    = (rem_sh >= {1'b0, dvs_r});
    rem_sub = rem_sh - {1'b0, dvs_r};
    rem_nxt = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    quo_nxt = {quo_r[DVD_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: take the magnitude up front, restore the sign at the end
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DVD_W-1];
      quo_r <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign qsigned  = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient = qsigned[AVG_W-1:0];
  assign done     = done_r;

endmodule
`default_nettype wire

// ===== rtl/core/windowed_average_alarm_monitor.sv =====
// Top level: sample ring in RAM, running sum, divider, alarm decision and register port.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  in_      | input     | in_valid/in_stall  | in_temperature (s20), in_pressure (u24)
//  out_     | output    | out_valid/out_stall| out_status (2), out_average (s20),
//           |           |                    | out_rise (s21)
//  APB      | input     | psel/penable/pready| paddr (4), pwdata/prdata (32)
//
// The result waits on the divider, which resolves one quotient bit per cycle, and is
// loaded into the output register once the divider is done and the output is free.
// The block works on one item at a time; in_stall is high from acceptance until the
// result has been moved into the output register.
// A held result waits in the output register while the next item is accepted.
// Reset is synchronous, active low, and empties the window; the ring RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module windowed_average_alarm_monitor
  import wam_pkg::*;
#(
  parameter int WINDOW = 10
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [TEMP_W-1:0] in_temperature,
  input  wire logic        [PRES_W-1:0] in_pressure,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic             [STAT_W-1:0] out_status,
  output logic signed      [AVG_W-1:0]  out_average,
  output logic signed      [RISE_W-1:0] out_rise,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic        [CFG_AW-1:0] paddr,
  input  wire logic        [CFG_DW-1:0] pwdata,
  output logic             [CFG_DW-1:0] prdata,
  output logic                          pready
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = TEMP_W + $clog2(WINDOW);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;

  // configuration registers
  logic [PRES_W-1:0] pres_limit_r;
  logic [TEMP_W-1:0] temp_limit_r;
  logic [RLIM_W-1:0] rise_limit_r;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_limit_r <= PRES_LIMIT_RST;
      temp_limit_r <= TEMP_LIMIT_RST;
      rise_limit_r <= RISE_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PRES_LIMIT: pres_limit_r <= pwdata[PRES_W-1:0];
        REG_TEMP_LIMIT: temp_limit_r <= pwdata[TEMP_W-1:0];
        REG_RISE_LIMIT: rise_limit_r <= pwdata[RLIM_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PRES_LIMIT: prdata = CFG_DW'(pres_limit_r);
      REG_TEMP_LIMIT: prdata = CFG_DW'(temp_limit_r);
      REG_RISE_LIMIT: prdata = CFG_DW'(rise_limit_r);
      default:        prdata = '0;
    endcase
  end

  // control and window state
  logic [2:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         fill_r;
  logic [IDX_W-1:0]         oldest_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [AVG_W-1:0]  prev_avg_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [PRES_W-1:0]        pres_r;

  logic                     in_acc;
  logic                     full;
  logic [CNT_W:0]           slot_raw;
  logic [CNT_W:0]           slot_wrap;
  logic [IDX_W-1:0]         wr_slot;
  logic [IDX_W-1:0]         oldest_inc;
  logic signed [TEMP_W-1:0] old_temp;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]         fill_nxt;
  logic                     wr_en;
  logic                     out_free;

  logic                     div_done;
  logic signed [AVG_W-1:0]  div_q;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (fill_r == CNT_W'(WINDOW));
  assign out_free = !out_valid || !out_stall;
  assign wr_en    = (state_r == ST_READ);

  always_comb begin
    slot_raw   = {1'b0, fill_r} + (CNT_W + 1)'(oldest_r);
    slot_wrap  = (slot_raw >= (CNT_W + 1)'(WINDOW)) ? slot_raw - (CNT_W + 1)'(WINDOW)
                                                    : slot_raw;
    oldest_inc = (oldest_r == IDX_W'(WINDOW - 1)) ? '0 : oldest_r + 1'b1;
    wr_slot    = full ? oldest_r : slot_wrap[IDX_W-1:0];
    fill_nxt   = full ? fill_r : fill_r + 1'b1;
    // drop the oldest sample once the window is full
    sum_wide   = (SUM_W + 1)'(sum_r) + (SUM_W + 1)'(temp_r)
               - (full ? (SUM_W + 1)'(old_temp) : '0);
    sum_nxt    = sum_wide[SUM_W-1:0];
  end

  wam_ram #(
    .WIDTH (TEMP_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_slot),
    .wdata (temp_r),
    .re    (in_acc),
    .raddr (oldest_r),
    .rdata (old_temp)
  );

  wam_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (wr_en),
    .dividend (sum_nxt),
    .divisor  (fill_nxt),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc)   state_nxt = ST_READ;
      ST_READ:               state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default:               state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= '0;
      oldest_r   <= '0;
      sum_r      <= '0;
      prev_avg_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        fill_r <= fill_nxt;
        sum_r  <= sum_nxt;
        if (full) begin
          oldest_r <= oldest_inc;
        end
      end
      if (state_r == ST_OUT && out_free) begin
        prev_avg_r <= div_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      temp_r <= in_temperature;
      pres_r <= in_pressure;
    end
  end

  // alarm decision
  logic signed [RISE_W-1:0] rise;
  logic                     melt;
  logic                     fast;
  status_t                  status;

  always_comb begin
    rise = RISE_W'(div_q) - RISE_W'(prev_avg_r);
    melt = (pres_r > pres_limit_r) || (temp_r > $signed(temp_limit_r));
    fast = (rise > $signed({2'b00, rise_limit_r}));
    priority if (melt) begin
      status = STATUS_MELTDOWN;
    end else if (fast) begin
      status = STATUS_RISE;
    end else begin
      status = STATUS_NORMAL;
    end
  end

  // output register
  logic load_out;
  assign load_out = (state_r == ST_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status  <= status;
      out_average <= div_q;
      out_rise    <= rise;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the windowed average alarm monitor: random handshakes, APB limits.
`timescale 1ns / 1ps
module tb_top;
  import wam_pkg::*;

  localparam int WINDOW = 10;
  localparam int PHASE_ITEMS = 255;
  localparam reg_idx_t REG_UNUSED = 2'd3;

  typedef struct {
    status_t             status;
    logic [AVG_W-1:0]    average;
    logic [RISE_W-1:0]   rise;
  } alarm_t;

  // Tracks the ring of temperatures and the limits; holds the alarms still owed.
  class alarm_scoreboard;
    logic [PRES_W-1:0]        pres_limit;
    logic signed [TEMP_W-1:0] temp_limit;
    logic [RLIM_W-1:0]        rise_limit;
    logic signed [TEMP_W-1:0] ring [WINDOW];
    longint                   ring_sum;
    int unsigned              held;
    int unsigned              oldest;
    alarm_t                   alarm_q[$];
    int                       errors;

    function new();
      pres_limit = PRES_LIMIT_RST;
      temp_limit = TEMP_LIMIT_RST;
      rise_limit = RISE_LIMIT_RST;
      ring_sum   = 0;
      held       = 0;
      oldest     = 0;
      errors     = 0;
    endfunction

    function int pending();
      return alarm_q.size();
    endfunction

    // Bits above each register's width are dropped; unknown indexes are ignored.
    function void write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
      case (reg_idx_t'(addr >> 2))
        REG_PRES_LIMIT: pres_limit = data[PRES_W-1:0];
        REG_TEMP_LIMIT: temp_limit = data[TEMP_W-1:0];
        REG_RISE_LIMIT: rise_limit = data[RLIM_W-1:0];
        default: ;
      endcase
    endfunction

    function int window_mean();
      if (held == 0) return 0;
      return int'(ring_sum / longint'(held));
    endfunction

    function void note_sample(logic signed [TEMP_W-1:0] temp, logic [PRES_W-1:0] pres);
      int          prev;
      int          now;
      int          rise;
      int          limit;
      int unsigned slot;
      alarm_t      e;
      prev = window_mean();
      if (held >= WINDOW) begin
        // evict the oldest sample and reuse its slot
        slot = oldest;
        ring_sum -= ring[slot];
        oldest = (slot + 1) % WINDOW;
      end else begin
        slot = (oldest + held) % WINDOW;
        held++;
      end
      ring[slot] = temp;
      ring_sum += temp;
      now   = window_mean();
      rise  = now - prev;
      limit = rise_limit;
      if (pres > pres_limit || temp > temp_limit) begin
        e.status = STATUS_MELTDOWN;
      end else if (rise > limit) begin
        e.status = STATUS_RISE;
      end else begin
        e.status = STATUS_NORMAL;
      end
      e.average = now[AVG_W-1:0];
      e.rise    = rise[RISE_W-1:0];
      alarm_q.insert(alarm_q.size(), e);
    endfunction

    task flag_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_result(status_t st, logic [AVG_W-1:0] avg, logic [RISE_W-1:0] rise);
      alarm_t e;
      if (alarm_q.size() == 0) begin
        flag_mismatch($sformatf("result with none owed: status %0d avg %h rise %h",
                                st, avg, rise));
        return;
      end
      e = alarm_q[0];
      alarm_q.delete(0);
      if (st !== e.status)
        flag_mismatch($sformatf("status %0d, want %0d", st, e.status));
      if (avg !== e.average)
        flag_mismatch($sformatf("average %h, want %h", avg, e.average));
      if (rise !== e.rise)
        flag_mismatch($sformatf("rise %h, want %h", rise, e.rise));
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [TEMP_W-1:0] in_temperature;
  logic        [PRES_W-1:0] in_pressure;
  logic                     out_valid;
  logic                     out_stall;
  logic        [STAT_W-1:0] out_status;
  logic signed [AVG_W-1:0]  out_average;
  logic signed [RISE_W-1:0] out_rise;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic        [CFG_AW-1:0] paddr;
  logic        [CFG_DW-1:0] pwdata;
  logic        [CFG_DW-1:0] prdata;
  logic                     pready;

  alarm_scoreboard sb;
  bit              calm;
  int              level;

  windowed_average_alarm_monitor #(.WINDOW(WINDOW)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_temperature(in_temperature), .in_pressure(in_pressure),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_average(out_average), .out_rise(out_rise),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 31);
  end

  // Sample at the falling edge: everything seen here holds until the next rising edge.
  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_valid && !out_stall)
      sb.check_result(out_status, out_average, out_rise);
  end

  task automatic send_sample(input logic signed [TEMP_W-1:0] t, input logic [PRES_W-1:0] p);
    logic taken;
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_temperature <= t;
    in_pressure    <= p;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sb.note_sample(t, p);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] data);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end while (!done);
    sb.write_reg({idx, 2'b00}, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Garbage in the upper bits must be dropped by the block.
  task automatic set_limits(input logic [PRES_W-1:0] pl, input logic [TEMP_W-1:0] tl,
                            input logic [RLIM_W-1:0] rl);
    logic [CFG_DW-1:0] data;
    data = $urandom;
    data[PRES_W-1:0] = pl;
    write_reg(REG_PRES_LIMIT, data);
    data = $urandom;
    data[TEMP_W-1:0] = tl;
    write_reg(REG_TEMP_LIMIT, data);
    data = $urandom;
    data[RLIM_W-1:0] = rl;
    write_reg(REG_RISE_LIMIT, data);
    write_reg(REG_UNUSED, $urandom);
  endtask

  task automatic random_sample();
    logic signed [TEMP_W-1:0] t;
    logic        [PRES_W-1:0] p;
    int                       sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1: begin
        t = TEMP_W'($urandom);
        p = PRES_W'($urandom);
      end
      2: begin
        t = $urandom_range(1) ? {1'b0, {(TEMP_W-1){1'b1}}} : {1'b1, {(TEMP_W-1){1'b0}}};
        p = $urandom_range(1) ? {PRES_W{1'b1}} : '0;
      end
      3: begin
        t = TEMP_W'(level);
        p = sb.pres_limit + PRES_W'($urandom_range(2)) - 1'b1;
      end
      4: begin
        t = sb.temp_limit + TEMP_W'($urandom_range(2)) - 1'b1;
        p = PRES_W'($urandom_range(20000));
      end
      default: begin
        // drift a plausible reading, now and then jump to provoke a rapid rise
        level += $urandom_range(64) - 32;
        if ($urandom_range(11) == 0) level += $urandom_range(4000) - 800;
        if (level > 500000 || level < -500000) level = 0;
        t = TEMP_W'(level);
        p = PRES_W'($urandom_range(30000));
      end
    endcase
    send_sample(t, p);
  endtask

  task automatic random_phase();
    repeat (PHASE_ITEMS) random_sample();
    wait_idle();
  endtask

  initial begin
    int guard;
    sb             = new();
    calm           = 1'b0;
    level          = 1600;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_temperature <= '0;
    in_pressure    <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset limits; the first sample rises from a zero average
    send_sample(100, 0);
    send_sample(32000, 24000);
    send_sample(32001, 0);
    send_sample(0, 24001);
    send_sample(524287, 0);
    send_sample(-524288, 24'hFFFFFF);
    send_sample(-3, 24000);
    repeat (WINDOW) send_sample(0, 0);
    // rise equal to the limit stays normal, one above raises the alarm
    send_sample(800, 0);
    send_sample(810, 0);
    repeat (3) send_sample(524287, 0);
    repeat (2) send_sample(-524288, 0);
    wait_idle();

    set_limits(24'hFFFFFF, 20'h7FFFF, 19'h7FFFF);
    random_phase();
    set_limits(24'h000000, 20'h80000, 19'h00000);
    random_phase();
    calm = 1'b1;
    set_limits(PRES_LIMIT_RST, TEMP_LIMIT_RST, RISE_LIMIT_RST);
    random_phase();
    calm = 1'b0;
    set_limits(PRES_W'($urandom), TEMP_W'($urandom), RLIM_W'($urandom_range(2000)));
    random_phase();
    set_limits(PRES_W'($urandom), TEMP_W'($urandom), RLIM_W'($urandom));
    random_phase();
    set_limits(30000, 16000, 40);
    random_phase();

    guard = 0;
    while (sb.pending() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    if (sb.pending() != 0) sb.flag_mismatch("alarms still owed at the end");
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/wam_pkg.sv
rtl/core/wam_ram.sv
rtl/core/wam_div.sv
rtl/core/windowed_average_alarm_monitor.sv
tb/sv/tb_top.sv
